[rtl/nvrgb_pkg.sv]
// ----------------------------------------------------------------------------
// nvrgb_pkg
// Shared types and constants of the nv12 quad to rgb32 converter: colour
// coefficients, configuration register indexes and the words that travel
// between the front end, the quad queue and the pixel back end.
// ----------------------------------------------------------------------------
package nvrgb_pkg;

	// register indexes on the configuration port
	localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_QUARTER_MODE = 2'd2;

	localparam int CFG_W   = 13;
	localparam int IDX_W   = 24;
	localparam int TERM_W  = 26;
	localparam int YP_W    = 26;
	localparam int SUM_W   = 27;

	// bt.601 coefficients, 16 fractional bits
	localparam logic signed [17:0] K_Y  = 18'sd76309;
	localparam logic signed [17:0] K_RV = 18'sd104597;
	localparam logic signed [16:0] K_GU = 17'sd25675;
	localparam logic signed [17:0] K_GV = 18'sd53279;
	localparam logic signed [18:0] K_BU = 19'sd132201;

	// one quad on its way from the front end to the back end
	typedef struct packed {
		logic [IDX_W-1:0]         top_idx;
		logic [IDX_W-1:0]         bot_idx;
		logic [7:0]               luma_tl;
		logic [7:0]               luma_tr;
		logic [7:0]               luma_bl;
		logic [7:0]               luma_br;
		logic signed [TERM_W-1:0] cr;
		logic signed [TERM_W-1:0] cg;
		logic signed [TERM_W-1:0] cb;
		logic                     quarter;
	} quad_t;

	// one finished pixel word
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic             last;
	} pixel_t;

endpackage

[rtl/nvrgb_fifo.sv]
// ----------------------------------------------------------------------------
// nvrgb_fifo
// Small synchronous fifo on flip-flops, first-word fall-through. Depth must
// be a power of two of at least two.
// ----------------------------------------------------------------------------
module nvrgb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW:0]      wr_q;
	logic [AW:0]      rd_q;
	logic             do_push;
	logic             do_pop;

	assign empty   = (wr_q == rd_q);
	assign full    = (wr_q[AW] != rd_q[AW]) && (wr_q[AW-1:0] == rd_q[AW-1:0]);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q[AW-1:0]] <= wdata;
		end
	end

endmodule

[rtl/nvrgb_front.sv]
// ----------------------------------------------------------------------------
// nvrgb_front
// Front end: holds the frame configuration and the quad position, accepts
// quads, works out the top and bottom row base indexes and the chroma terms
// in three stages and hands each quad to the quad queue.
// ----------------------------------------------------------------------------
module nvrgb_front #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write_en,
	input  logic [1:0]                  cfg_index,
	input  logic [nvrgb_pkg::CFG_W-1:0] cfg_data,
	input  logic                        push,
	output logic                        full,
	input  logic [7:0]                  luma_top_left,
	input  logic [7:0]                  luma_top_right,
	input  logic [7:0]                  luma_bottom_left,
	input  logic [7:0]                  luma_bottom_right,
	input  logic [7:0]                  chroma_first,
	input  logic [7:0]                  chroma_second,
	output logic                        q_push,
	output nvrgb_pkg::quad_t            q_data,
	input  logic                        q_full
);
	import nvrgb_pkg::*;

	localparam int WD_W   = $clog2(MAX_WIDTH + 1);
	localparam int HT_W   = $clog2(MAX_HEIGHT + 1);
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int PROD_W = WD_W + HT_W;

	// clamp to 2..maxv and force even
	function automatic logic [13:0] clamp_even(logic [CFG_W-1:0] v, logic [13:0] maxv);
		logic [13:0] r;
		r = {1'b0, v};
		if (r < 14'd2) begin
			r = 14'd2;
		end
		if (r > maxv) begin
			r = maxv;
		end
		return {r[13:1], 1'b0};
	endfunction

	localparam logic [WD_W-1:0] W_RST = WD_W'(clamp_even(13'd640, 14'(MAX_WIDTH)));
	localparam logic [HT_W-1:0] H_RST = HT_W'(clamp_even(13'd480, 14'(MAX_HEIGHT)));

	logic [WD_W-1:0]  w_q;
	logic [HT_W-1:0]  h_q;
	logic             quarter_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic [WD_W-1:0] hw;
	logic [HT_W-1:0] hh;
	logic            adv;
	logic            accept;
	logic            wrap0;
	logic [WD_W-1:0] c_cur;
	logic [WD_W-1:0] c_inc;
	logic [HT_W-1:0] r_pre;
	logic [HT_W-1:0] q_cur;
	logic [HT_W-1:0] q_inc;

	// stage 1: position and raw samples
	logic             v_s1;
	logic [COL_W-1:0] c_s1;
	logic [ROW_W-1:0] q_s1;
	logic [7:0]       tl_s1, tr_s1, bl_s1, br_s1;
	logic signed [8:0] cv_s1, cu_s1;
	logic             quarter_s1;

	// stage 2: multiplier operands and chroma terms
	logic                     v_s2;
	logic [HT_W-1:0]          row_s2;
	logic [WD_W-1:0]          wsel_s2;
	logic [IDX_W-1:0]         col_s2;
	logic [IDX_W-1:0]         colm_s2;
	logic [7:0]               tl_s2, tr_s2, bl_s2, br_s2;
	logic signed [TERM_W-1:0] cr_s2, cg_s2, cb_s2;
	logic                     quarter_s2;

	// stage 3: row base product
	logic                     v_s3;
	logic [PROD_W-1:0]        prod_s3;
	logic [IDX_W-1:0]         col_s3;
	logic [IDX_W-1:0]         colm_s3;
	logic [7:0]               tl_s3, tr_s3, bl_s3, br_s3;
	logic signed [TERM_W-1:0] cr_s3, cg_s3, cb_s3;
	logic                     quarter_s3;

	assign hw     = w_q >> 1;
	assign hh     = h_q >> 1;
	assign adv    = !(v_s3 && q_full);
	assign full   = !adv;
	assign accept = push && adv;

	// column left out of frame by a size change wraps before use
	assign wrap0 = (WD_W'(col_q) >= hw);
	assign c_cur = wrap0 ? '0 : WD_W'(col_q);
	assign r_pre = HT_W'(row_q) + HT_W'(wrap0);
	assign q_cur = (r_pre >= hh) ? '0 : r_pre;
	assign c_inc = c_cur + 1'b1;
	assign q_inc = q_cur + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q       <= W_RST;
			h_q       <= H_RST;
			quarter_q <= 1'b0;
			col_q     <= '0;
			row_q     <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					CFG_FRAME_WIDTH: begin
						w_q <= WD_W'(clamp_even(cfg_data, 14'(MAX_WIDTH)));
					end
					CFG_FRAME_HEIGHT: begin
						h_q <= HT_W'(clamp_even(cfg_data, 14'(MAX_HEIGHT)));
					end
					CFG_QUARTER_MODE: begin
						quarter_q <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end
			if (accept) begin
				if (c_inc >= hw) begin
					col_q <= '0;
					row_q <= (q_inc >= hh) ? '0 : ROW_W'(q_inc);
				end else begin
					col_q <= COL_W'(c_inc);
					row_q <= ROW_W'(q_cur);
				end
			end
			if (adv) begin
				v_s1 <= accept;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1       <= COL_W'(c_cur);
			q_s1       <= ROW_W'(q_cur);
			tl_s1      <= luma_top_left;
			tr_s1      <= luma_top_right;
			bl_s1      <= luma_bottom_left;
			br_s1      <= luma_bottom_right;
			// flipping the top bit and sign extending gives the byte minus 128
			cv_s1      <= {~chroma_first[7], ~chroma_first[7], chroma_first[6:0]};
			cu_s1      <= {~chroma_second[7], ~chroma_second[7], chroma_second[6:0]};
			quarter_s1 <= quarter_q;

			if (quarter_s1) begin
				row_s2  <= hh - 1'b1 - HT_W'(q_s1);
				wsel_s2 <= hw;
				col_s2  <= IDX_W'(c_s1);
				colm_s2 <= IDX_W'(c_s1) - IDX_W'(hw);
			end else begin
				row_s2  <= h_q - 1'b1 - (HT_W'(q_s1) << 1);
				wsel_s2 <= w_q;
				col_s2  <= IDX_W'(c_s1) << 1;
				colm_s2 <= (IDX_W'(c_s1) << 1) - IDX_W'(w_q);
			end
			tl_s2      <= tl_s1;
			tr_s2      <= tr_s1;
			bl_s2      <= bl_s1;
			br_s2      <= br_s1;
			cr_s2      <= K_RV * cv_s1;
			cg_s2      <= K_GU * cu_s1 + K_GV * cv_s1;
			cb_s2      <= K_BU * cu_s1;
			quarter_s2 <= quarter_s1;

			prod_s3    <= PROD_W'(row_s2) * PROD_W'(wsel_s2);
			col_s3     <= col_s2;
			colm_s3    <= colm_s2;
			tl_s3      <= tl_s2;
			tr_s3      <= tr_s2;
			bl_s3      <= bl_s2;
			br_s3      <= br_s2;
			cr_s3      <= cr_s2;
			cg_s3      <= cg_s2;
			cb_s3      <= cb_s2;
			quarter_s3 <= quarter_s2;
		end
	end

	assign q_push          = v_s3 && !q_full;
	assign q_data.top_idx  = IDX_W'(prod_s3) + col_s3;
	// bottom row sits one frame row below the top row in memory order
	assign q_data.bot_idx  = IDX_W'(prod_s3) + colm_s3;
	assign q_data.luma_tl  = tl_s3;
	assign q_data.luma_tr  = tr_s3;
	assign q_data.luma_bl  = bl_s3;
	assign q_data.luma_br  = br_s3;
	assign q_data.cr       = cr_s3;
	assign q_data.cg       = cg_s3;
	assign q_data.cb       = cb_s3;
	assign q_data.quarter  = quarter_s3;

endmodule

[rtl/nvrgb_back.sv]
// ----------------------------------------------------------------------------
// nvrgb_back
// Back end: walks the pixels of the queue's head quad (top-left only in
// quarter mode), one a cycle while its small result fifo has room, scales
// luma, adds the chroma terms, shifts, clips and leaves the words there.
// ----------------------------------------------------------------------------
module nvrgb_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  nvrgb_pkg::quad_t            q_data,
	input  logic                        q_empty,
	output logic                        q_pop,
	input  logic                        pop,
	output logic                        empty,
	output logic [nvrgb_pkg::IDX_W-1:0] pixel_index,
	output logic [7:0]                  red,
	output logic [7:0]                  green,
	output logic [7:0]                  blue,
	output logic                        last_of_quad
);
	import nvrgb_pkg::*;

	function automatic logic [7:0] clip_shift(logic signed [SUM_W-1:0] s);
		logic [7:0] r;
		if (s[SUM_W-1]) begin
			r = 8'd0;
		end else if (|s[SUM_W-2:24]) begin
			r = 8'hff;
		end else begin
			r = s[23:16];
		end
		return r;
	endfunction

	logic [1:0] k_q;
	logic       adv;
	logic       issue;
	logic       last_now;
	logic [7:0] y_sel;
	logic [IDX_W-1:0] idx_sel;

	logic                     v_s1;
	logic [7:0]               y_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic signed [TERM_W-1:0] cr_s1, cg_s1, cb_s1;
	logic                     last_s1;
	logic signed [8:0]        ym16;

	logic                     v_s2;
	logic signed [YP_W-1:0]   yp_s2;
	logic [IDX_W-1:0]         idx_s2;
	logic signed [TERM_W-1:0] cr_s2, cg_s2, cb_s2;
	logic                     last_s2;

	logic signed [SUM_W-1:0] r_sum, g_sum, b_sum;
	pixel_t                  px_in;
	pixel_t                  px_out;
	logic                    of_full;

	assign adv      = !(v_s2 && of_full);
	assign issue    = adv && !q_empty;
	assign last_now = q_data.quarter || (k_q == 2'd3);
	assign q_pop    = issue && last_now;

	// pixel order: top-left, bottom-left, top-right, bottom-right
	always_comb begin
		case (k_q)
			2'd0:    y_sel = q_data.luma_tl;
			2'd1:    y_sel = q_data.luma_bl;
			2'd2:    y_sel = q_data.luma_tr;
			default: y_sel = q_data.luma_br;
		endcase
	end
	assign idx_sel = (k_q[0] ? q_data.bot_idx : q_data.top_idx) + IDX_W'(k_q[1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q  <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (issue) begin
				k_q <= last_now ? 2'd0 : k_q + 1'b1;
			end
			if (adv) begin
				v_s1 <= issue;
				v_s2 <= v_s1;
			end
		end
	end

	assign ym16 = signed'({1'b0, y_s1}) - 9'sd16;

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s1    <= y_sel;
			idx_s1  <= idx_sel;
			cr_s1   <= q_data.cr;
			cg_s1   <= q_data.cg;
			cb_s1   <= q_data.cb;
			last_s1 <= last_now;

			yp_s2   <= K_Y * ym16;
			idx_s2  <= idx_s1;
			cr_s2   <= cr_s1;
			cg_s2   <= cg_s1;
			cb_s2   <= cb_s1;
			last_s2 <= last_s1;
		end
	end

	assign r_sum = SUM_W'(yp_s2) + SUM_W'(cr_s2);
	assign g_sum = SUM_W'(yp_s2) - SUM_W'(cg_s2);
	assign b_sum = SUM_W'(yp_s2) + SUM_W'(cb_s2);

	assign px_in.idx   = idx_s2;
	assign px_in.red   = clip_shift(r_sum);
	assign px_in.green = clip_shift(g_sum);
	assign px_in.blue  = clip_shift(b_sum);
	assign px_in.last  = last_s2;

	nvrgb_fifo #(
		.WIDTH ($bits(pixel_t)),
		.DEPTH (4)
	) u_result_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (v_s2),
		.wdata  (px_in),
		.full   (of_full),
		.pop    (pop),
		.rdata  (px_out),
		.empty  (empty)
	);

	assign pixel_index  = px_out.idx;
	assign red          = px_out.red;
	assign green        = px_out.green;
	assign blue         = px_out.blue;
	assign last_of_quad = px_out.last;

endmodule

[rtl/nv12_to_rgb32_converter_core.sv]
// ----------------------------------------------------------------------------
// nv12_to_rgb32_converter_core
// Converts 2x2 nv12 luma quads with their shared chroma pair into bt.601
// rgb pixels with bottom-up frame indexes.
// ----------------------------------------------------------------------------
// The result port carries one pixel word per cycle, so a quad yields four
// words in full mode and one word in quarter mode; the pixel sequencer of
// the back end, feeding that single result port, sets the pace. Quads are
// taken while earlier ones are still in flight: a three-stage front end
// (position, operands, row-base multiply) feeds a four-entry quad queue, and
// the two-stage back end feeds a four-word result fifo, so a new quad can be
// pushed every cycle until the queue fills. The user must write
// configuration only while nothing is in flight; the block does not
// enforce this. Width and height are clamped to 2..MAX_WIDTH and
// 2..MAX_HEIGHT and rounded down to even.
module nv12_to_rgb32_converter_core #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write_en,
	input  logic [1:0]                  cfg_index,
	input  logic [nvrgb_pkg::CFG_W-1:0] cfg_data,
	input  logic                        push,
	output logic                        full,
	input  logic [7:0]                  luma_top_left,
	input  logic [7:0]                  luma_top_right,
	input  logic [7:0]                  luma_bottom_left,
	input  logic [7:0]                  luma_bottom_right,
	input  logic [7:0]                  chroma_first,
	input  logic [7:0]                  chroma_second,
	input  logic                        pop,
	output logic                        empty,
	output logic [nvrgb_pkg::IDX_W-1:0] pixel_index,
	output logic [7:0]                  red,
	output logic [7:0]                  green,
	output logic [7:0]                  blue,
	output logic                        last_of_quad
);
	import nvrgb_pkg::*;

	logic  q_push;
	logic  q_full;
	logic  q_pop;
	logic  q_empty;
	quad_t q_wdata;
	quad_t q_rdata;

	nvrgb_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write_en      (cfg_write_en),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.push              (push),
		.full              (full),
		.luma_top_left     (luma_top_left),
		.luma_top_right    (luma_top_right),
		.luma_bottom_left  (luma_bottom_left),
		.luma_bottom_right (luma_bottom_right),
		.chroma_first      (chroma_first),
		.chroma_second     (chroma_second),
		.q_push            (q_push),
		.q_data            (q_wdata),
		.q_full            (q_full)
	);

	nvrgb_fifo #(
		.WIDTH ($bits(quad_t)),
		.DEPTH (4)
	) u_quad_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	nvrgb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_data       (q_rdata),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.pop          (pop),
		.empty        (empty),
		.pixel_index  (pixel_index),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.last_of_quad (last_of_quad)
	);

endmodule

[rtl/nvrgb_checker.sv]
// ----------------------------------------------------------------------------
// nvrgb_checker
// Port-level checks of the converter: result words belong to accepted quads,
// quad framing by last_of_quad, and index order inside a full-mode quad.
// ----------------------------------------------------------------------------
module nvrgb_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cfg_write_en,
	input logic [1:0]                  cfg_index,
	input logic [nvrgb_pkg::CFG_W-1:0] cfg_data,
	input logic                        push,
	input logic                        full,
	input logic                        pop,
	input logic                        empty,
	input logic [nvrgb_pkg::IDX_W-1:0] pixel_index,
	input logic [7:0]                  red,
	input logic [7:0]                  green,
	input logic [7:0]                  blue,
	input logic                        last_of_quad
);
	import nvrgb_pkg::*;

	logic             in_acc;
	logic             out_acc;
	logic [4:0]       pend_q;
	logic             quarter_q;
	logic [1:0]       pos_q;
	logic [IDX_W-1:0] idx0_q;

	assign in_acc  = push && !full;
	assign out_acc = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= '0;
			quarter_q <= 1'b0;
			pos_q     <= '0;
			idx0_q    <= '0;
		end else begin
			pend_q <= pend_q + 5'(in_acc) - 5'(out_acc && last_of_quad);
			if (cfg_write_en && (cfg_index == CFG_QUARTER_MODE)) begin
				quarter_q <= cfg_data[0];
			end
			if (out_acc) begin
				pos_q <= last_of_quad ? 2'd0 : pos_q + 1'b1;
				if (pos_q == 2'd0) begin
					idx0_q <= pixel_index;
				end
			end
		end
	end

	// a waiting word holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(pixel_index) && $stable(red)
			&& $stable(green) && $stable(blue) && $stable(last_of_quad))
		else $error("result word changed while waiting");

	// no word without an accepted quad still owing its last word
	a_owed: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pend_q != 5'd0)
		else $error("result word without a pending quad");

	a_quarter_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && quarter_q |-> last_of_quad)
		else $error("quarter mode word not marked last");

	a_full_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !quarter_q |-> last_of_quad == (pos_q == 2'd3))
		else $error("full mode quad framing broken");

	// top-right sits right of top-left
	a_full_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !quarter_q && pos_q == 2'd2 |-> pixel_index == idx0_q + 1'b1)
		else $error("full mode index order broken");

endmodule

bind nv12_to_rgb32_converter_core nvrgb_checker u_checker (.*);
